@@ design/mtlc_pkg.sv @@
// Shared types and constants for the matrix tile layout converter.
// No dependencies; used by every module in the design folder.
package mtlc_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_DIRECTION   = 3'd0,
        REG_BATCH_COUNT = 3'd1,
        REG_ROWS        = 3'd2,
        REG_COLS        = 3'd3,
        REG_TILE_LOG2   = 3'd4
    } cfg_reg_t;

    localparam int unsigned DIM_W   = 13;
    localparam int unsigned PAD_W   = 14;
    localparam int unsigned INDEX_W = 40;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned BATCH_W = 12;
    localparam int unsigned MAT_W   = 28;

    localparam logic [DIM_W-1:0] BATCH_LIMIT = 13'd4096;
    localparam logic [2:0]       TILE_MIN    = 3'd2;
    localparam logic [2:0]       TILE_MAX    = 3'd6;

    // Cycles from a register write until the derived values are usable
    localparam logic [1:0] SETTLE_CYCLES = 2'd3;

    // Values derived from the configuration registers
    typedef struct packed {
        logic             dir;
        logic [DIM_W-1:0] nb;
        logic [DIM_W-1:0] nr;
        logic [DIM_W-1:0] nc;
        logic [2:0]       t;
        logic [5:0]       m;
        logic [PAD_W-1:0] pr;
        logic [PAD_W-1:0] pc;
        logic [19:0]      tile_row_step;
        logic [18:0]      tile_back;
    } cfg_derived_t;

    // Derived values for the reset configuration: 1 x 1 x 1, tile side 16
    localparam cfg_derived_t DERIVED_RESET = '{
        dir:           1'b0,
        nb:            13'd1,
        nr:            13'd1,
        nc:            13'd1,
        t:             3'd4,
        m:             6'd15,
        pr:            14'd16,
        pc:            14'd16,
        tile_row_step: 20'd256,
        tile_back:     19'd15
    };
    localparam logic [MAT_W-1:0] MAT_SIZE_RESET = 28'd256;

    typedef struct packed {
        logic [INDEX_W-1:0] dst_index;
        logic [DATA_W-1:0]  data;
    } result_t;

endpackage

@@ design/mtlc_cfg_regs.sv @@
// Configuration registers and the tile geometry derived from them.
// Depends on mtlc_pkg.
module mtlc_cfg_regs #(
    parameter int unsigned MAX_DIM = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    input  logic [2:0]                  cfg_index,
    input  logic [12:0]                 cfg_data,
    output logic                        cfg_ready,
    output mtlc_pkg::cfg_derived_t      derived,
    output logic [mtlc_pkg::MAT_W-1:0]  mat_size,
    output logic                        busy,
    output logic                        clear
);

    localparam logic [mtlc_pkg::DIM_W-1:0] DIM_CAP =
        (MAX_DIM > 8191) ? 13'd8191 : 13'(MAX_DIM);

    logic                          direction_reg;
    logic [mtlc_pkg::DIM_W-1:0]    batch_count_reg;
    logic [mtlc_pkg::DIM_W-1:0]    rows_reg;
    logic [mtlc_pkg::DIM_W-1:0]    cols_reg;
    logic [2:0]                    tile_log2_reg;
    mtlc_pkg::cfg_derived_t        derived_reg;
    mtlc_pkg::cfg_derived_t        derived_next;
    logic [mtlc_pkg::MAT_W-1:0]    mat_size_reg;
    logic [mtlc_pkg::MAT_W-1:0]    mat_size_next;
    logic [1:0]                    settle_reg;
    logic                          write_en;
    logic                          listed;
    logic [mtlc_pkg::PAD_W-1:0]    mul_a;
    logic [mtlc_pkg::PAD_W-1:0]    mul_b;
    logic [mtlc_pkg::PAD_W-1:0]    m_pad;

    assign cfg_ready = 1'b1;
    assign write_en  = cfg_valid && cfg_ready;

    always_comb
    begin
        unique case (cfg_index) inside
            mtlc_pkg::REG_DIRECTION,
            mtlc_pkg::REG_BATCH_COUNT,
            mtlc_pkg::REG_ROWS,
            mtlc_pkg::REG_COLS,
            mtlc_pkg::REG_TILE_LOG2: listed = 1'b1;
            default:                 listed = 1'b0;
        endcase
    end

    assign clear = write_en && listed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg   <= 1'b0;
            batch_count_reg <= 13'd1;
            rows_reg        <= 13'd1;
            cols_reg        <= 13'd1;
            tile_log2_reg   <= 3'd4;
        end
        else if (write_en)
        begin
            unique case (cfg_index)
                mtlc_pkg::REG_DIRECTION:   direction_reg   <= cfg_data[0];
                mtlc_pkg::REG_BATCH_COUNT: batch_count_reg <= cfg_data;
                mtlc_pkg::REG_ROWS:        rows_reg        <= cfg_data;
                mtlc_pkg::REG_COLS:        cols_reg        <= cfg_data;
                mtlc_pkg::REG_TILE_LOG2:   tile_log2_reg   <= cfg_data[2:0];
                default:                   ;
            endcase
        end
    end

    // Clamp dimensions, round the padded size up to whole tiles
    always_comb
    begin
        derived_next.dir = direction_reg;
        if (batch_count_reg == '0)
            derived_next.nb = 13'd1;
        else if (batch_count_reg > mtlc_pkg::BATCH_LIMIT)
            derived_next.nb = mtlc_pkg::BATCH_LIMIT;
        else
            derived_next.nb = batch_count_reg;

        if (rows_reg == '0)
            derived_next.nr = 13'd1;
        else if (rows_reg > DIM_CAP)
            derived_next.nr = DIM_CAP;
        else
            derived_next.nr = rows_reg;

        if (cols_reg == '0)
            derived_next.nc = 13'd1;
        else if (cols_reg > DIM_CAP)
            derived_next.nc = DIM_CAP;
        else
            derived_next.nc = cols_reg;

        if (tile_log2_reg < mtlc_pkg::TILE_MIN)
            derived_next.t = mtlc_pkg::TILE_MIN;
        else if (tile_log2_reg > mtlc_pkg::TILE_MAX)
            derived_next.t = mtlc_pkg::TILE_MAX;
        else
            derived_next.t = tile_log2_reg;

        derived_next.m  = 6'((7'd1 << derived_next.t) - 7'd1);
        m_pad           = 14'(derived_next.m);
        derived_next.pr = (14'(derived_next.nr) + m_pad) & ~m_pad;
        derived_next.pc = (14'(derived_next.nc) + m_pad) & ~m_pad;
        derived_next.tile_row_step = 20'(derived_next.pc) << derived_next.t;
        derived_next.tile_back =
            (19'(derived_next.nc) << derived_next.t) - 19'(derived_next.nc);
    end

    // Matrix size in the destination layout, one stage after the geometry
    assign mul_a = derived_reg.dir ? 14'(derived_reg.nr) : derived_reg.pr;
    assign mul_b = derived_reg.dir ? 14'(derived_reg.nc) : derived_reg.pc;
    assign mat_size_next = 28'(mul_a) * 28'(mul_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            derived_reg  <= mtlc_pkg::DERIVED_RESET;
            mat_size_reg <= mtlc_pkg::MAT_SIZE_RESET;
            settle_reg   <= '0;
        end
        else
        begin
            derived_reg  <= derived_next;
            mat_size_reg <= mat_size_next;
            if (write_en)
                settle_reg <= mtlc_pkg::SETTLE_CYCLES;
            else if (settle_reg != '0)
                settle_reg <= settle_reg - 2'd1;
        end
    end

    assign derived  = derived_reg;
    assign mat_size = mat_size_reg;
    assign busy     = (settle_reg != '0);

endmodule

@@ design/mtlc_index_gen.sv @@
// Position counters and destination index for each accepted element.
// Depends on mtlc_pkg; geometry comes from mtlc_cfg_regs.
module mtlc_index_gen #(
    parameter int unsigned ELEM_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mtlc_pkg::cfg_derived_t              derived,
    input  logic [mtlc_pkg::MAT_W-1:0]          mat_size,
    input  logic                                clear,
    input  logic                                step,
    input  logic [mtlc_pkg::DATA_W-1:0]         value,
    output logic                                produced,
    output mtlc_pkg::result_t                   result
);

    localparam logic [63:0] WIDE_MASK =
        (ELEM_BITS >= 64) ? {64{1'b1}} : ((64'd1 << ELEM_BITS) - 64'd1);
    localparam logic [mtlc_pkg::DATA_W-1:0] DATA_MASK = WIDE_MASK[31:0];

    logic [mtlc_pkg::BATCH_W-1:0] batch_idx_reg,  batch_idx_next;
    logic [mtlc_pkg::DIM_W-1:0]   row_pos_reg,    row_pos_next;
    logic [mtlc_pkg::DIM_W-1:0]   col_pos_reg,    col_pos_next;
    logic [mtlc_pkg::INDEX_W-1:0] batch_base_reg, batch_base_next;
    logic [mtlc_pkg::INDEX_W-1:0] row_base_reg,   row_base_next;

    logic [mtlc_pkg::DIM_W-1:0]   m13;
    logic [mtlc_pkg::PAD_W-1:0]   side;
    logic [mtlc_pkg::DIM_W-1:0]   col_hi;
    logic [19:0]                  tiled_off;
    logic                         batch_last;
    logic [mtlc_pkg::BATCH_W-1:0] nb_idx_next;
    logic [mtlc_pkg::INDEX_W-1:0] nb_base_next;
    logic                         col_last;
    logic                         row_last;
    logic                         col_in_last;
    logic                         row_in_last;
    logic [mtlc_pkg::PAD_W-1:0]   col_jump;
    logic [mtlc_pkg::PAD_W-1:0]   row_jump;

    assign m13    = 13'(derived.m);
    assign side   = 14'd1 << derived.t;
    assign col_hi = col_pos_reg >> derived.t;

    // Tile column, row in tile and column in tile occupy disjoint bit ranges
    assign tiled_off = (20'(col_hi) << {derived.t, 1'b0})
                     | (20'(row_pos_reg & m13) << derived.t)
                     | 20'(col_pos_reg & m13);

    always_comb
    begin
        result.data = value & DATA_MASK;
        if (derived.dir)
        begin
            result.dst_index = row_base_reg + 40'(col_pos_reg);
            produced = (row_pos_reg < derived.nr) && (col_pos_reg < derived.nc);
        end
        else
        begin
            result.dst_index = row_base_reg + 40'(tiled_off);
            produced = 1'b1;
        end
    end

    assign batch_last   = (13'(batch_idx_reg) + 13'd1) >= derived.nb;
    assign nb_idx_next  = batch_last ? '0 : batch_idx_reg + 12'd1;
    assign nb_base_next = batch_last ? '0 : batch_base_reg + 40'(mat_size);

    assign col_last    = (14'(col_pos_reg) + 14'd1) >= 14'(derived.nc);
    assign row_last    = (14'(row_pos_reg) + 14'd1) >= 14'(derived.nr);
    assign col_in_last = (col_pos_reg & m13) == m13;
    assign row_in_last = (row_pos_reg & m13) == m13;
    assign col_jump    = 14'(col_pos_reg & ~m13) + side;
    assign row_jump    = 14'(row_pos_reg & ~m13) + side;

    always_comb
    begin
        batch_idx_next  = batch_idx_reg;
        row_pos_next    = row_pos_reg;
        col_pos_next    = col_pos_reg;
        batch_base_next = batch_base_reg;
        row_base_next   = row_base_reg;
        if (!derived.dir)
        begin
            // Row-major walk; row_base tracks the start of the tile row
            if (!col_last)
                col_pos_next = col_pos_reg + 13'd1;
            else
            begin
                col_pos_next = '0;
                if (!row_last)
                begin
                    row_pos_next = row_pos_reg + 13'd1;
                    if (row_in_last)
                        row_base_next = row_base_reg + 40'(derived.tile_row_step);
                end
                else
                begin
                    row_pos_next    = '0;
                    batch_idx_next  = nb_idx_next;
                    batch_base_next = nb_base_next;
                    row_base_next   = nb_base_next;
                end
            end
        end
        else
        begin
            // Tiled walk; row_base tracks batch_base + row_pos * nc
            if (!col_in_last)
                col_pos_next = col_pos_reg + 13'd1;
            else if (!row_in_last)
            begin
                col_pos_next  = col_pos_reg & ~m13;
                row_pos_next  = row_pos_reg + 13'd1;
                row_base_next = row_base_reg + 40'(derived.nc);
            end
            else if (col_jump < derived.pc)
            begin
                col_pos_next  = 13'(col_jump);
                row_pos_next  = row_pos_reg & ~m13;
                row_base_next = row_base_reg - 40'(derived.tile_back);
            end
            else if (row_jump < derived.pr)
            begin
                // Last row of the tile row to first row of the next: one row on
                col_pos_next  = '0;
                row_pos_next  = 13'(row_jump);
                row_base_next = row_base_reg + 40'(derived.nc);
            end
            else
            begin
                col_pos_next    = '0;
                row_pos_next    = '0;
                batch_idx_next  = nb_idx_next;
                batch_base_next = nb_base_next;
                row_base_next   = nb_base_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_idx_reg  <= '0;
            row_pos_reg    <= '0;
            col_pos_reg    <= '0;
            batch_base_reg <= '0;
            row_base_reg   <= '0;
        end
        else if (clear)
        begin
            batch_idx_reg  <= '0;
            row_pos_reg    <= '0;
            col_pos_reg    <= '0;
            batch_base_reg <= '0;
            row_base_reg   <= '0;
        end
        else if (step)
        begin
            batch_idx_reg  <= batch_idx_next;
            row_pos_reg    <= row_pos_next;
            col_pos_reg    <= col_pos_next;
            batch_base_reg <= batch_base_next;
            row_base_reg   <= row_base_next;
        end
    end

endmodule

@@ design/mtlc_out_buf.sv @@
// Result register with a skid stage that takes one more result under a stall.
// Depends on mtlc_pkg.
module mtlc_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mtlc_pkg::result_t  push_data,
    input  logic               out_stall,
    output logic               out_valid,
    output mtlc_pkg::result_t  out_data,
    output logic               full
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    mtlc_pkg::result_t out_data_reg;
    mtlc_pkg::result_t skid_data_reg;
    logic              pop;

    assign pop = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            // Input is held off while the skid stage is occupied
            if (pop)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_data_reg <= skid_data_reg;
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
                out_data_reg <= push_data;
            else
                skid_data_reg <= push_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign full      = skid_valid_reg;

endmodule

@@ design/matrix_tile_layout_converter_unit.sv @@
// An accepted element's result, if any, goes to the output or skid register.
// Throughput: one element per cycle while item_stall is low; the position counters
// and running row bases advance with a single 40-bit add per element.
// A configuration write holds input off while the tile geometry and matrix size
// are recomputed; a write to a listed register also clears the counters.
// Reset (rst_n, asynchronous): default registers, counters zero, output empty.
module matrix_tile_layout_converter_unit #(
    parameter int unsigned ELEM_BITS = 32,
    parameter int unsigned MAX_DIM   = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [31:0] value,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [39:0] dst_index,
    output logic [31:0] data_out
);

    mtlc_pkg::cfg_derived_t       derived;
    logic [mtlc_pkg::MAT_W-1:0]   mat_size;
    logic                         busy;
    logic                         clear;
    logic                         accept;
    logic                         produced;
    mtlc_pkg::result_t            result;
    mtlc_pkg::result_t            out_data;
    logic                         full;

    mtlc_cfg_regs #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .derived   (derived),
        .mat_size  (mat_size),
        .busy      (busy),
        .clear     (clear)
    );

    assign item_stall = busy || full;
    assign accept     = item_valid && !item_stall;

    mtlc_index_gen #(
        .ELEM_BITS (ELEM_BITS)
    ) u_index (
        .clk      (clk),
        .rst_n    (rst_n),
        .derived  (derived),
        .mat_size (mat_size),
        .clear    (clear),
        .step     (accept),
        .value    (value),
        .produced (produced),
        .result   (result)
    );

    mtlc_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && produced),
        .push_data (result),
        .out_stall (result_stall),
        .out_valid (result_valid),
        .out_data  (out_data),
        .full      (full)
    );

    assign dst_index = out_data.dst_index;
    assign data_out  = out_data.data;

`ifndef SYNTHESIS
    // Row-major to tiled always yields a result for each transaction
    a_dir0_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !derived.dir |=> result_valid)
        else $error("element accepted in tiling mode gave no result");

    // A configuration write blocks input until the geometry settles
    a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> item_stall ##1 item_stall ##1 item_stall)
        else $error("input accepted before configuration settled");

    // The skid stage is only occupied behind a held result
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> result_valid)
        else $error("skid stage holds a result while output is empty");
`endif

endmodule
